/* hdl/heartbeat_node_monitor_unit_assert.svh */
// Assertion macros for the heartbeat node monitor checker.
// Needs signals named clk and rst_n in the scope that uses them.
`ifndef HEARTBEAT_NODE_MONITOR_UNIT_ASSERT_SVH
`define HEARTBEAT_NODE_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HNM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication a fixed number of cycles later, disabled during reset.
`define HNM_ASSERT_LATER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

/* hdl/hnm_pkg.sv */
// Package for the heartbeat node monitor: field codes, identifier masks,
// state class decoding. No dependencies.
package hnm_pkg;

    localparam int NODE_COUNT_DEFAULT = 128;
    localparam int NODE_W             = 7;
    localparam int TIME_W             = 32;
    localparam int STATUS_W           = 8;
    localparam int TIMEOUT_W          = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

    localparam logic [10:0] HB_MASK = 11'h700;
    localparam logic [10:0] EM_MASK = 11'h780;
    localparam logic [10:0] EM_CODE = 11'h080;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [1:0] KIND_EMERGENCY = 2'd1;
    localparam logic [1:0] KIND_OTHER     = 2'd2;
    localparam logic [1:0] KIND_CHECK     = 2'd3;

    localparam logic [7:0] STATUS_INIT    = 8'd0;
    localparam logic [7:0] STATUS_STOPPED = 8'd4;
    localparam logic [7:0] STATUS_OPER    = 8'd5;
    localparam logic [7:0] STATUS_PREOP   = 8'd127;

    localparam logic [2:0] CLASS_INIT    = 3'd0;
    localparam logic [2:0] CLASS_STOPPED = 3'd1;
    localparam logic [2:0] CLASS_OPER    = 3'd2;
    localparam logic [2:0] CLASS_PREOP   = 3'd3;
    localparam logic [2:0] CLASS_NONE    = 3'd4;

    function automatic logic [2:0] decode_class(input logic [STATUS_W-1:0] status);
        logic [2:0] cls;
        unique case (status)
            STATUS_INIT:    cls = CLASS_INIT;
            STATUS_STOPPED: cls = CLASS_STOPPED;
            STATUS_OPER:    cls = CLASS_OPER;
            STATUS_PREOP:   cls = CLASS_PREOP;
            default:        cls = CLASS_NONE;
        endcase
        return cls;
    endfunction

endpackage

/* hdl/hnm_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/heartbeat_node_monitor_unit.sv */
// Top level of the heartbeat node monitor.
// Depends on hnm_pkg and hnm_ram.
// Usage:
//  - Input channel: drive operation, frame_identifier, first_data_byte,
//    query_node and now_ms together with start. A transaction is taken at
//    every rising edge with start high and busy low. busy never rises, so
//    one transaction can be taken every cycle.
//  - Result channel: result_valid strobes for one cycle with item_kind,
//    node_number, node_active, node_status and state_class. Exactly one
//    result follows each transaction, in order.
//  - Pipeline: a taken transaction passes the stage 1 registers, then the
//    result registers. Stage 1 covers the registered read port of the node
//    RAM that holds status and last-heard time.
//  - Throughput is one transaction per cycle.
//  - Configuration: cfg_wr_en writes cfg_wr_data into the timeout register
//    at the next edge. Write it only while no transaction is in flight.
//  - Reset clears all active flags at once (flip-flops) and loads a 2000 ms
//    timeout. The RAM is not cleared: a read entry is used only while its
//    active flag is set, which implies it was written.
//  - The receiver cannot stall; results are not held.
module heartbeat_node_monitor_unit
    import hnm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic [10:0]          frame_identifier,
    input  logic [STATUS_W-1:0]  first_data_byte,
    input  logic [NODE_W-1:0]    query_node,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    output logic                 result_valid,
    output logic [1:0]           item_kind,
    output logic [NODE_W-1:0]    node_number,
    output logic                 node_active,
    output logic [STATUS_W-1:0]  node_status,
    output logic [2:0]           state_class
);

    localparam int AW     = $clog2(NODE_COUNT);
    localparam int ENTRY_W = STATUS_W + TIME_W;

    // Input side
    logic                accept;
    logic [NODE_W-1:0]   in_node;
    logic                in_range;
    logic [1:0]          in_kind;
    logic                hb_write;

    // Stage 1 registers: the accepted transaction while the RAM read completes
    logic                s1_valid_reg,  s1_valid_next;
    logic [1:0]          s1_kind_reg,   s1_kind_next;
    logic [NODE_W-1:0]   s1_node_reg,   s1_node_next;
    logic                s1_range_reg,  s1_range_next;
    logic [STATUS_W-1:0] s1_data_reg,   s1_data_next;
    logic [TIME_W-1:0]   s1_now_reg,    s1_now_next;

    // Configuration and node state
    logic [TIMEOUT_W-1:0]  timeout_reg, timeout_next;
    logic [NODE_COUNT-1:0] active_reg,  active_next;

    // Result registers
    logic                res_valid_reg,  res_valid_next;
    logic [1:0]          res_kind_reg,   res_kind_next;
    logic [NODE_W-1:0]   res_node_reg,   res_node_next;
    logic                res_active_reg, res_active_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [2:0]          res_class_reg,  res_class_next;

    // Stage 1 datapath
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [STATUS_W-1:0] ram_status;
    logic [TIME_W-1:0]   ram_time;
    logic [AW-1:0]       s1_idx;
    logic [TIME_W-1:0]   elapsed;
    logic                timed_out;
    logic                s1_flag;
    logic                check_clear;
    logic                check_active;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Classify the transaction at the input
    always_comb
    begin
        in_node  = (operation == OP_CHECK) ? query_node : frame_identifier[NODE_W-1:0];
        in_range = ({1'b0, in_node} < (NODE_W + 1)'(NODE_COUNT));
        if (operation == OP_CHECK)
        begin
            in_kind = KIND_CHECK;
        end
        else if ((frame_identifier & HB_MASK) == HB_MASK)
        begin
            in_kind = KIND_HEARTBEAT;
        end
        else if ((frame_identifier & EM_MASK) == EM_CODE)
        begin
            in_kind = KIND_EMERGENCY;
        end
        else
        begin
            in_kind = KIND_OTHER;
        end
        hb_write = accept && (in_kind == KIND_HEARTBEAT) && in_range;
    end

    // Status and last-heard time live together; a heartbeat writes both
    // at accept, a check reads both at accept.
    hnm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (hb_write),
        .wr_addr (in_node[AW-1:0]),
        .wr_data ({first_data_byte, now_ms}),
        .rd_en   (accept && (operation == OP_CHECK)),
        .rd_addr (in_node[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign ram_status = ram_rd_data[ENTRY_W-1 -: STATUS_W];
    assign ram_time   = ram_rd_data[TIME_W-1:0];

    // Stage 1: timeout check against the entry just read
    always_comb
    begin
        s1_idx       = s1_node_reg[AW-1:0];
        s1_flag      = active_reg[s1_idx];
        elapsed      = s1_now_reg - ram_time;
        timed_out    = elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_reg};
        check_clear  = s1_valid_reg && (s1_kind_reg == KIND_CHECK) && s1_range_reg
                       && s1_flag && timed_out;
        check_active = s1_range_reg && s1_flag && !timed_out;
    end

    // Next state: capture input, update flags, build result
    always_comb
    begin
        s1_valid_next = accept;
        s1_kind_next  = in_kind;
        s1_node_next  = in_node;
        s1_range_next = in_range;
        s1_data_next  = first_data_byte;
        s1_now_next   = now_ms;

        timeout_next = cfg_wr_en ? cfg_wr_data : timeout_reg;

        // Drop a timed-out node first; a heartbeat taken in the same cycle
        // is the later transaction and wins.
        active_next = active_reg;
        if (check_clear)
        begin
            active_next[s1_idx] = 1'b0;
        end
        if (hb_write)
        begin
            active_next[in_node[AW-1:0]] = 1'b1;
        end

        res_valid_next  = s1_valid_reg;
        res_kind_next   = s1_kind_reg;
        res_node_next   = s1_node_reg;
        res_active_next = 1'b0;
        res_status_next = '0;
        res_class_next  = CLASS_NONE;
        case (s1_kind_reg)
            KIND_HEARTBEAT:
            begin
                if (s1_range_reg)
                begin
                    res_active_next = 1'b1;
                    res_status_next = s1_data_reg;
                    res_class_next  = decode_class(s1_data_reg);
                end
            end
            KIND_CHECK:
            begin
                if (check_active)
                begin
                    res_active_next = 1'b1;
                    res_status_next = ram_status;
                    res_class_next  = decode_class(ram_status);
                end
            end
            default:
            begin
                res_active_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            active_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            timeout_reg   <= timeout_next;
            active_reg    <= active_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        s1_kind_reg    <= s1_kind_next;
        s1_node_reg    <= s1_node_next;
        s1_range_reg   <= s1_range_next;
        s1_data_reg    <= s1_data_next;
        s1_now_reg     <= s1_now_next;
        res_kind_reg   <= res_kind_next;
        res_node_reg   <= res_node_next;
        res_active_reg <= res_active_next;
        res_status_reg <= res_status_next;
        res_class_reg  <= res_class_next;
    end

    assign result_valid = res_valid_reg;
    assign item_kind    = res_kind_reg;
    assign node_number  = res_node_reg;
    assign node_active  = res_active_reg;
    assign node_status  = res_status_reg;
    assign state_class  = res_class_reg;

endmodule

/* hdl/hnm_checker.sv */
// Port-level checker for heartbeat_node_monitor_unit, bound to the top level.
// Depends on hnm_pkg and heartbeat_node_monitor_unit_assert.svh.
`include "heartbeat_node_monitor_unit_assert.svh"

module hnm_checker
    import hnm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 operation,
    input logic                 result_valid,
    input logic [1:0]           item_kind,
    input logic                 node_active,
    input logic [STATUS_W-1:0]  node_status,
    input logic [2:0]           state_class
);

    // Every transaction yields its result once through the stage 1 and result registers.
    `HNM_ASSERT_LATER(a_result_latency, start && !busy, 2, result_valid, "missing result")

    // Check transactions report as checks.
    `HNM_ASSERT_LATER(a_check_kind, start && !busy && (operation == OP_CHECK), 2,
        item_kind == KIND_CHECK, "check reported with wrong kind")

    // Inactive results carry no status.
    `HNM_ASSERT_NOW(a_inactive_empty, result_valid && !node_active,
        (node_status == '0) && (state_class == CLASS_NONE), "inactive result has status")

    // Emergency and other frames never report an active node.
    `HNM_ASSERT_NOW(a_plain_frame, result_valid
        && ((item_kind == KIND_EMERGENCY) || (item_kind == KIND_OTHER)),
        !node_active, "plain frame reported active")

endmodule

bind heartbeat_node_monitor_unit hnm_checker u_hnm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .result_valid     (result_valid),
    .item_kind        (item_kind),
    .node_active      (node_active),
    .node_status      (node_status),
    .state_class      (state_class)
);
